// ===== sv/sbs_pkg.sv =====
// sbs_pkg: shared types and constants for the sorted-table search block
// no dependencies; imported by sorted_table_binary_search_top
package sbs_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_FINAL,
    S_DONE
  } sbs_state_t;

  // input item kinds (carried on tuser)
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // search variants
  localparam logic VAR_CLASSIC = 1'b0;
  localparam logic VAR_LOWER   = 1'b1;

  // register indexes (byte address bit 2)
  localparam logic REG_VARIANT = 1'b0;
  localparam logic REG_COUNT   = 1'b1;

  localparam int CFG_AW   = 3;
  localparam int CMP_W    = 5;
  localparam int COUNT_W  = 9;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;

  typedef logic [CMP_W-1:0] cmp_cnt_t;

  // comparison count with saturation at the top of its range
  function automatic cmp_cnt_t sat_add(input cmp_cnt_t cnt, input logic [1:0] inc);
    logic [CMP_W:0] sum;
    sum = (CMP_W+1)'(cnt) + (CMP_W+1)'(inc);
    if (sum[CMP_W]) begin
      return '1;
    end
    return sum[CMP_W-1:0];
  endfunction

endpackage

// ===== sv/sorted_table_binary_search_top.sv =====
// sorted_table_binary_search_top: table of signed entries with a binary search engine
// depends on sbs_pkg (types, codes, saturating counter helper)
//
//  channel | direction | transfer contents
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | tuser kind; tdata index[7:0], value[39:8]
//  out_    | master    | tdata found[0], position[8:1], comparisons[13:9]
//  cfg_    | apb slave | 0x0 variant, 0x4 entry_count
//
// steps: a load is written straight into the table. a query runs probes of a table
// read, then a compare on the registered data, a closing bounds check (plus a final
// equality read in the lower-bound variant), a hand-off and a return to idle: at most
// ceil(log2(n+1)) probes in the classic variant, at most ceil(log2(n)) in the lower-bound one.
// reset: synchronous active low; clears control state and the configuration registers, the
// table itself keeps whatever it held and reads of unwritten entries are undefined.
// stalls: in_tready is high only while the engine is idle; a finished result
// waits in the output register, so a new item is taken while it is held.
module sorted_table_binary_search_top #(
  parameter int DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [39:0]                 in_tdata,   // index[7:0], value[39:8]
  input  logic                        in_tuser,   // kind
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // found, position[8:1], comparisons[13:9], zero pad
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sbs_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import sbs_pkg::*;

  localparam int AW = $clog2(DEPTH);       // table address width
  localparam int NW = $clog2(DEPTH + 1);   // wide enough to hold DEPTH itself

  // configuration registers
  logic                 variant_r;
  logic [COUNT_W-1:0]   count_r;
  logic                 cfg_wr;

  // table memory
  logic [VALUE_W-1:0]   mem [DEPTH];
  logic [VALUE_W-1:0]   rd_data_r;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;

  // search state
  sbs_state_t           state_r, state_nxt;
  logic                 mode_r, mode_nxt;
  logic [VALUE_W-1:0]   target_r, target_nxt;
  logic [NW-1:0]        lo_r, lo_nxt;
  logic [NW-1:0]        hi_r, hi_nxt;      // exclusive bound (classic), inclusive (lower)
  logic [NW-1:0]        mid_r, mid_nxt;
  logic                 found_r, found_nxt;
  logic [NW-1:0]        pos_r, pos_nxt;
  cmp_cnt_t             cnt_r, cnt_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  cmp_cnt_t             out_cnt_r, out_cnt_nxt;

  logic [NW:0]          mid_sum;
  logic [NW-1:0]        mid;
  logic [NW-1:0]        n_used;
  logic                 in_xfer;
  logic                 entry_lt;
  logic                 entry_eq;

  // ---------------------------------------------------------------------------
  // configuration port: writes land on the access phase, reads are combinational
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= VAR_CLASSIC;
      count_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_VARIANT: variant_r <= cfg_pwdata[0];
        REG_COUNT:   count_r   <= cfg_pwdata[COUNT_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_VARIANT: cfg_prdata = {31'd0, variant_r};
      REG_COUNT:   cfg_prdata = {{(32-COUNT_W){1'b0}}, count_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input side: loads write straight into the table while idle
  // ---------------------------------------------------------------------------
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign mem_we    = in_xfer && (in_tuser == KIND_LOAD) && (32'(in_tdata[7:0]) < 32'(DEPTH));

  // entries in use, clamped to the table depth
  assign n_used = (32'(count_r) > 32'(DEPTH)) ? NW'(DEPTH) : NW'(count_r);

  // midpoint: floor of (left + right) / 2, right being hi-1 for the classic search
  assign mid_sum = (NW+1)'(lo_r) + (NW+1)'(hi_r) - ((mode_r == VAR_CLASSIC) ? (NW+1)'(1) : '0);
  assign mid     = mid_sum[NW:1];

  // the final equality test of the lower-bound search reads at the right bound
  assign rd_addr = (state_r == S_PROBE && !(lo_r < hi_r)) ? AW'(hi_r) : AW'(mid);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_tdata[7:0])] <= in_tdata[39:8];
    end
    rd_data_r <= mem[rd_addr];
  end

  assign entry_lt = $signed(rd_data_r) < $signed(target_r);
  assign entry_eq = rd_data_r == target_r;

  // ---------------------------------------------------------------------------
  // search sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    target_r    <= target_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    target_nxt    = target_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_tuser == KIND_QUERY) begin
          mode_nxt   = variant_r;
          target_nxt = in_tdata[39:8];
          lo_nxt     = '0;
          hi_nxt     = (variant_r == VAR_LOWER) ? n_used - NW'(1) : n_used;
          found_nxt  = 1'b0;
          pos_nxt    = '0;
          cnt_nxt    = '0;
          // empty table under the lower-bound search: no probe at all
          state_nxt  = (variant_r == VAR_LOWER && n_used == '0) ? S_DONE : S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else if (mode_r == VAR_LOWER) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        state_nxt = S_PROBE;
        if (mode_r == VAR_CLASSIC) begin
          if (entry_eq) begin
            cnt_nxt   = sat_add(cnt_r, 2'd1);
            found_nxt = 1'b1;
            pos_nxt   = mid_r;
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = sat_add(cnt_r, 2'd2);
            if (entry_lt) begin
              lo_nxt = mid_r + NW'(1);
            end else begin
              hi_nxt = mid_r;
            end
          end
        end else begin
          cnt_nxt = sat_add(cnt_r, 2'd1);
          if (entry_lt) begin
            lo_nxt = mid_r + NW'(1);
          end else begin
            hi_nxt = mid_r;
          end
        end
      end
      S_FINAL: begin
        cnt_nxt   = sat_add(cnt_r, 2'd1);
        found_nxt = entry_eq;
        pos_nxt   = entry_eq ? hi_r : '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_pos_nxt   = POS_W'(pos_r);
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_pos_r, out_found_r};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // compare always works on data read in the cycle before
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP || state_r == S_FINAL) |-> $past(state_r) == S_PROBE)
    else $error("compare without a preceding table read");

  // the search window never turns inside out
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> lo_r <= hi_r)
    else $error("search bounds crossed");

  // a new result only appears out of the hand-off state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside hand-off");

  // no new item is taken while a search is running
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && in_tvalid) |=> state_r != S_IDLE || $past(state_r) == S_CMP)
    else $error("item accepted mid-search");

endmodule
